// ----- rtl/tbm_pkg.sv -----
// ----------------------------------------------------------------------------
// tbm_pkg
// Shared types and constants for the tilt to button mapper.
// ----------------------------------------------------------------------------
package tbm_pkg;

	// input modes
	localparam logic [2:0] MODE_NONE   = 3'd0;
	localparam logic [2:0] MODE_STICK  = 3'd1;
	localparam logic [2:0] MODE_DPAD   = 3'd2;
	localparam logic [2:0] MODE_ACTION = 3'd3;
	localparam logic [2:0] MODE_TRIG   = 3'd4;

	// configuration register indexes
	localparam logic [2:0] REG_MODE   = 3'd0;
	localparam logic [2:0] REG_INVERT = 3'd1;
	localparam logic [2:0] REG_BASE_X = 3'd2;
	localparam logic [2:0] REG_BASE_Y = 3'd3;
	localparam logic [2:0] REG_DZ     = 3'd4;
	localparam logic [2:0] REG_GAIN_X = 3'd5;
	localparam logic [2:0] REG_GAIN_Y = 3'd6;
	localparam logic [2:0] REG_SKIP   = 3'd7;

	// button bits
	localparam logic [9:0] BTN_RIGHT = 10'h001;
	localparam logic [9:0] BTN_DOWN  = 10'h002;
	localparam logic [9:0] BTN_LEFT  = 10'h004;
	localparam logic [9:0] BTN_UP    = 10'h008;
	localparam logic [9:0] BTN_CIRC  = 10'h010;
	localparam logic [9:0] BTN_CROSS = 10'h020;
	localparam logic [9:0] BTN_SQR   = 10'h040;
	localparam logic [9:0] BTN_TRI   = 10'h080;
	localparam logic [9:0] BTN_LT    = 10'h100;
	localparam logic [9:0] BTN_RT    = 10'h200;

	localparam logic [14:0] TAN_Q16   = 15'd27146;  // tan(22.5 deg) in Q0.16
	localparam logic [14:0] STICK_MAX = 15'd16384;  // 1.0 in Q1.14
	localparam logic [23:0] MAG_MAX   = 24'hFFFFFF;
	localparam int          DIV_STEPS = 25;         // 24 quotient bits plus overflow bit

	localparam logic [12:0] DZ_ONE = 13'd4096;      // 1.0 in Q1.12

	typedef struct packed {
		logic [2:0]         mode;
		logic [1:0]         invert;
		logic signed [15:0] base_x;
		logic signed [15:0] base_y;
		logic [11:0]        dead_zone;
		logic [15:0]        gain_x;
		logic [15:0]        gain_y;
		logic [11:0]        skip_offset;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic div_step;
		logic mag;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic op_reset;
		logic out_free;
	} sts_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_DIV,
		ST_MAG,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/tbm_ctrl.sv -----
// ----------------------------------------------------------------------------
// tbm_ctrl
// Sequencer: steps one request through multiply, divide, magnitude and commit.
// ----------------------------------------------------------------------------
module tbm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  tbm_pkg::sts_t sts,
	output tbm_pkg::cmd_t cmd
);
	import tbm_pkg::*;

	state_t     state_q, state_d;
	logic [4:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				// reset requests need no arithmetic
				state_d  = sts.op_reset ? ST_DONE : ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				cnt_d    = '0;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 5'd1;
				if (cnt_q == 5'(DIV_STEPS - 1)) begin
					state_d = ST_MAG;
				end
			end
			ST_MAG: begin
				cmd.mag = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/tbm_datapath.sv -----
// ----------------------------------------------------------------------------
// tbm_datapath
// Per-axis deadzone curve (multipliers, shared-divisor restoring divider),
// button mapping, tilt-held state and the output register.
// ----------------------------------------------------------------------------
module tbm_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  tbm_pkg::cfg_t       cfg,
	input  tbm_pkg::cmd_t       cmd,
	output tbm_pkg::sts_t       sts,
	input  logic                operation,
	input  logic signed [15:0]  tilt_x,
	input  logic signed [15:0]  tilt_y,
	input  logic [9:0]          held_elsewhere,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [9:0]          press_mask,
	output logic [9:0]          release_mask,
	output logic                stick_valid,
	output logic signed [15:0]  stick_x,
	output logic signed [15:0]  stick_y
);
	import tbm_pkg::*;

	// input stage
	logic signed [16:0] dx_raw, dy_raw, dx_d, dy_d;
	logic signed [16:0] dx_q, dy_q;
	logic               op_q;
	logic [9:0]         he_q;

	// multiply stages
	logic [15:0] ax, ay;
	logic        outx_q, outy_q;
	logic [15:0] ex_q, ey_q;
	logic [31:0] g2x_q, g2y_q;
	logic [12:0] dzc;
	logic [25:0] den_q;
	logic [47:0] prodx, prody;

	// divider
	logic [51:0] remx_q, remy_q;
	logic [49:0] dvs_q;
	logic [24:0] qx_q, qy_q;
	logic        gex, gey;

	// magnitude stage
	logic [24:0] sumx, sumy;
	logic [23:0] magx_q, magy_q;

	// commit logic
	logic        nzx, nzy, posx, posy, negy, negx;
	logic [39:0] tx, ty;
	logic        near_h, near_v;
	logic [9:0]  dpad, action, hx, hy, h, blocked, up, down;
	logic [14:0] cx, cy;
	logic [9:0]  press_d, rel_d, held_d;
	logic        sv_d, sws_d;
	logic signed [15:0] stx_d, sty_d;

	// state and output register
	logic        out_valid_q;
	logic [9:0]  held_q;
	logic        sws_q;
	logic [9:0]  press_q, rel_q;
	logic        sv_q;
	logic signed [15:0] stx_q, sty_q;

	// ---- load ----
	always_comb begin
		dx_raw = 17'(tilt_x) - 17'($signed(cfg.base_x));
		dy_raw = 17'(tilt_y) - 17'($signed(cfg.base_y));
		dx_d   = cfg.invert[0] ? -dx_raw : dx_raw;
		dy_d   = cfg.invert[1] ? -dy_raw : dy_raw;
	end

	// ---- multiplies ----
	always_comb begin
		ax    = dx_q[16] ? 16'(-dx_q) : dx_q[15:0];
		ay    = dy_q[16] ? 16'(-dy_q) : dy_q[15:0];
		dzc   = DZ_ONE - {1'b0, cfg.dead_zone};
		prodx = {32'b0, ex_q} * {16'b0, g2x_q};
		prody = {32'b0, ey_q} * {16'b0, g2y_q};
	end

	// ---- divide / magnitude ----
	always_comb begin
		gex  = remx_q >= {2'b0, dvs_q};
		gey  = remy_q >= {2'b0, dvs_q};
		sumx = {1'b0, qx_q[23:0]} + {11'b0, cfg.skip_offset, 2'b0};
		sumy = {1'b0, qy_q[23:0]} + {11'b0, cfg.skip_offset, 2'b0};
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= operation;
			he_q <= held_elsewhere;
			dx_q <= dx_d;
			dy_q <= dy_d;
		end
		if (cmd.mul1) begin
			outx_q <= ax > {4'b0, cfg.dead_zone};
			outy_q <= ay > {4'b0, cfg.dead_zone};
			ex_q   <= ax - {4'b0, cfg.dead_zone};
			ey_q   <= ay - {4'b0, cfg.dead_zone};
			g2x_q  <= {16'b0, cfg.gain_x} * {16'b0, cfg.gain_x};
			g2y_q  <= {16'b0, cfg.gain_y} * {16'b0, cfg.gain_y};
			den_q  <= {13'b0, dzc} * {13'b0, dzc};
		end
		if (cmd.mul2) begin
			remx_q <= {prodx, 4'b0};
			remy_q <= {prody, 4'b0};
			dvs_q  <= {den_q, 24'b0};
			qx_q   <= '0;
			qy_q   <= '0;
		end
		if (cmd.div_step) begin
			if (gex) begin
				remx_q <= remx_q - {2'b0, dvs_q};
			end
			if (gey) begin
				remy_q <= remy_q - {2'b0, dvs_q};
			end
			qx_q  <= {qx_q[23:0], gex};
			qy_q  <= {qy_q[23:0], gey};
			dvs_q <= dvs_q >> 1;
		end
		if (cmd.mag) begin
			// top quotient bit set means the quotient alone overflows 24 bits
			if (!outx_q) begin
				magx_q <= '0;
			end else if (qx_q[24] || sumx[24]) begin
				magx_q <= MAG_MAX;
			end else begin
				magx_q <= sumx[23:0];
			end
			if (!outy_q) begin
				magy_q <= '0;
			end else if (qy_q[24] || sumy[24]) begin
				magy_q <= MAG_MAX;
			end else begin
				magy_q <= sumy[23:0];
			end
		end
	end

	// ---- sector decode and button rules ----
	always_comb begin
		nzx  = magx_q != '0;
		nzy  = magy_q != '0;
		posx = !dx_q[16] && nzx;
		posy = !dy_q[16] && nzy;
		negx = dx_q[16] && nzx;
		negy = dy_q[16] && nzy;
		tx   = {16'b0, magx_q} * {25'b0, TAN_Q16};
		ty   = {16'b0, magy_q} * {25'b0, TAN_Q16};
		near_h = {magy_q, 16'b0} < tx;
		near_v = {magx_q, 16'b0} < ty;

		priority if (near_h) begin
			dpad = posx ? BTN_RIGHT : BTN_LEFT;
		end else if (near_v) begin
			dpad = posy ? BTN_DOWN : BTN_UP;
		end else if (posx) begin
			dpad = posy ? (BTN_RIGHT | BTN_DOWN) : (BTN_UP | BTN_RIGHT);
		end else begin
			dpad = posy ? (BTN_DOWN | BTN_LEFT) : (BTN_UP | BTN_LEFT);
		end

		priority if (magx_q > magy_q) begin
			action = posx ? BTN_CIRC : BTN_SQR;
		end else if (magy_q > magx_q) begin
			action = posy ? BTN_CROSS : BTN_TRI;
		end else if (posx) begin
			action = posy ? BTN_CROSS : BTN_CIRC;
		end else begin
			action = posy ? BTN_SQR : BTN_TRI;
		end

		cx = (magx_q > {9'b0, STICK_MAX}) ? STICK_MAX : magx_q[14:0];
		cy = (magy_q > {9'b0, STICK_MAX}) ? STICK_MAX : magy_q[14:0];
	end

	always_comb begin
		press_d = '0;
		rel_d   = '0;
		sv_d    = 1'b0;
		stx_d   = '0;
		sty_d   = '0;
		held_d  = held_q;
		sws_d   = sws_q;
		h       = held_q;
		hx      = '0;
		hy      = '0;
		blocked = '0;
		up      = '0;
		down    = '0;
		if (op_q) begin
			rel_d  = held_q;
			held_d = '0;
			if (sws_q) begin
				sv_d  = 1'b1;
				sws_d = 1'b0;
			end
		end else begin
			unique case (cfg.mode)
				MODE_STICK: begin
					sv_d  = 1'b1;
					stx_d = dx_q[16] ? -$signed({1'b0, cx}) : $signed({1'b0, cx});
					sty_d = dy_q[16] ? -$signed({1'b0, cy}) : $signed({1'b0, cy});
					sws_d = 1'b1;
				end
				MODE_DPAD, MODE_ACTION: begin
					hx = (cfg.mode == MODE_DPAD) ? (BTN_RIGHT | BTN_LEFT) : (BTN_SQR | BTN_CIRC);
					hy = (cfg.mode == MODE_DPAD) ? (BTN_UP | BTN_DOWN) : (BTN_TRI | BTN_CROSS);
					// an axis lets go only when it is back at zero
					if (!nzx) begin
						rel_d = rel_d | (h & hx);
						h     = h & ~hx;
					end
					if (!nzy) begin
						rel_d = rel_d | (h & hy);
						h     = h & ~hy;
					end
					if (nzx || nzy) begin
						blocked = he_q | h;
						press_d = ((cfg.mode == MODE_DPAD) ? dpad : action) & ~blocked;
						h       = h | press_d;
					end
					held_d = h;
				end
				MODE_TRIG: begin
					priority if (negy) begin
						down = BTN_LT | BTN_RT;
					end else if (!nzx) begin
						up = BTN_LT | BTN_RT;
					end else if (negx) begin
						down = BTN_LT;
						up   = BTN_RT;
					end else begin
						down = BTN_RT;
						up   = BTN_LT;
					end
					blocked = he_q | held_q;
					press_d = down & ~blocked;
					rel_d   = held_q & up;
					held_d  = (held_q & ~up) | press_d;
				end
				default: begin
				end
			endcase
		end
	end

	// ---- state and output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			held_q      <= '0;
			sws_q       <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
			held_q      <= held_d;
			sws_q       <= sws_d;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			press_q <= press_d;
			rel_q   <= rel_d;
			sv_q    <= sv_d;
			stx_q   <= stx_d;
			sty_q   <= sty_d;
		end
	end

	assign sts.op_reset  = op_q;
	assign sts.out_free  = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign press_mask    = press_q;
	assign release_mask  = rel_q;
	assign stick_valid   = sv_q;
	assign stick_x       = stx_q;
	assign stick_y       = sty_q;

endmodule

// ----- rtl/tilt_to_button_mapper_core.sv -----
// ----------------------------------------------------------------------------
// tilt_to_button_mapper_core
// Maps accelerometer tilt requests to stick values or button press/release
// masks.
//
// Input channel (in_valid/in_ready) takes one request: a tilt sample or a
// reset of tilt-held buttons. Output channel (out_valid/out_ready) returns
// exactly one result per request, in order. Configuration is a plain write
// port (cfg_we, cfg_index, cfg_data) with no wait states.
// A tilt sample passes through load, two multiply steps, 25 steps of the
// restoring divider (one quotient bit per cycle, both axes in parallel on
// a shared divisor), magnitude and commit before out_valid is raised.
// A reset request skips the arithmetic: from the first multiply step it
// goes straight to commit. One request is in flight at a time; in_ready
// is high only while the sequencer is idle.
// The result sits in an output register; a stalled receiver holds the
// sequencer at commit, but the next request is still accepted once the
// previous result is registered.
// Reset clears the config registers to defaults, held buttons and the stick
// flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
module tilt_to_button_mapper_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic signed [15:0] tilt_x,
	input  logic signed [15:0] tilt_y,
	input  logic [9:0]         held_elsewhere,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [9:0]         press_mask,
	output logic [9:0]         release_mask,
	output logic               stick_valid,
	output logic signed [15:0] stick_x,
	output logic signed [15:0] stick_y
);
	import tbm_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode        <= MODE_NONE;
			cfg_q.invert      <= '0;
			cfg_q.base_x      <= '0;
			cfg_q.base_y      <= '0;
			cfg_q.dead_zone   <= '0;
			cfg_q.gain_x      <= 16'd4096;
			cfg_q.gain_y      <= 16'd4096;
			cfg_q.skip_offset <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:   cfg_q.mode        <= cfg_data[2:0];
				REG_INVERT: cfg_q.invert      <= cfg_data[1:0];
				REG_BASE_X: cfg_q.base_x      <= cfg_data;
				REG_BASE_Y: cfg_q.base_y      <= cfg_data;
				REG_DZ:     cfg_q.dead_zone   <= cfg_data[11:0];
				REG_GAIN_X: cfg_q.gain_x      <= cfg_data;
				REG_GAIN_Y: cfg_q.gain_y      <= cfg_data;
				REG_SKIP:   cfg_q.skip_offset <= cfg_data[11:0];
			endcase
		end
	end

	tbm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tbm_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.cmd            (cmd),
		.sts            (sts),
		.operation      (operation),
		.tilt_x         (tilt_x),
		.tilt_y         (tilt_y),
		.held_elsewhere (held_elsewhere),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.press_mask     (press_mask),
		.release_mask   (release_mask),
		.stick_valid    (stick_valid),
		.stick_x        (stick_x),
		.stick_y        (stick_y)
	);

endmodule

// ----- rtl/tbm_checker.sv -----
// ----------------------------------------------------------------------------
// tbm_checker
// Port-level checks for the tilt to button mapper, bound to the top level.
// ----------------------------------------------------------------------------
module tbm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [9:0]         press_mask,
	input logic [9:0]         release_mask,
	input logic               stick_valid,
	input logic signed [15:0] stick_x,
	input logic signed [15:0] stick_y
);

	// one request in flight: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready high the cycle after a request was accepted");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(press_mask) && $stable(release_mask))
		else $error("stalled result dropped or changed");

	a_stick_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !stick_valid |-> stick_x == 16'sd0 && stick_y == 16'sd0)
		else $error("stick nonzero without stick_valid");

	a_mask_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (press_mask & release_mask) == 10'd0)
		else $error("button pressed and released in one result");

	a_stick_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> stick_x <= 16'sd16384 && stick_x >= -16'sd16384 &&
			stick_y <= 16'sd16384 && stick_y >= -16'sd16384)
		else $error("stick value outside +-1.0");

endmodule

bind tilt_to_button_mapper_core tbm_checker u_tbm_checker (.*);
